@@ src/ngh_pkg.sv @@
// Shared types, widths and constants of the noise gate with hold.
// Used by every module of the block; no dependencies.
`default_nettype none
package ngh_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int COEF_W      = 16;
	localparam int FRAC_W      = 16;                        // Q0.16 coefficients
	localparam int ENV_W       = SAMPLE_BITS + FRAC_W;      // Q16.16 envelope
	localparam int GAIN_FRAC   = 30;
	localparam int GAIN_W      = GAIN_FRAC + 1;             // Q1.30, at most 1.0
	localparam int THR_W       = 16;
	localparam int HOLD_W      = 16;
	localparam int CMP_W       = (ENV_W > THR_W + FRAC_W) ? ENV_W : THR_W + FRAC_W;
	localparam int TDATA_W     = ((SAMPLE_BITS + 7) / 8) * 8;

	// shared multiplier operands: A unsigned magnitude or coefficient, B signed
	localparam int A_W = ((COEF_W > SAMPLE_BITS) ? COEF_W : SAMPLE_BITS) + 1;
	localparam int B_W = ((ENV_W + 1) > (GAIN_W + 1)) ? ENV_W + 1 : GAIN_W + 1;
	localparam int P_W = A_W + B_W;

	localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_FRAC;

	localparam int CFG_AW = 3;
	localparam int CFG_DW = 16;

	typedef enum logic [CFG_AW-1:0] {
		REG_THRESHOLD  = 3'd0,
		REG_ENV_RISE   = 3'd1,
		REG_ENV_FALL   = 3'd2,
		REG_OPEN_COEF  = 3'd3,
		REG_CLOSE_COEF = 3'd4,
		REG_HOLD_LEN   = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [THR_W-1:0]  threshold_level;
		logic [COEF_W-1:0] env_rise_coef;
		logic [COEF_W-1:0] env_fall_coef;
		logic [COEF_W-1:0] open_coef;
		logic [COEF_W-1:0] close_coef;
		logic [HOLD_W-1:0] hold_length;
	} cfg_t;

	typedef enum logic [1:0] {
		MUL_ENV,
		MUL_GAIN,
		MUL_OUT
	} mul_sel_t;

	typedef struct packed {
		logic     load_in;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     env_upd;
		logic     gate_upd;
		logic     gain_upd;
		logic     out_load;
	} cmd_t;

endpackage
`default_nettype wire

@@ src/ngh_cfg_regs.sv @@
// Configuration register file of the noise gate.
// Depends on ngh_pkg.
`default_nettype none
module ngh_cfg_regs (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [ngh_pkg::CFG_AW-1:0]  cfg_addr,
	input  wire logic [ngh_pkg::CFG_DW-1:0]  cfg_wdata,
	output ngh_pkg::cfg_t                    cfg
);

	ngh_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold_level <= 16'd104;
			cfg_q.env_rise_coef   <= 16'd64185;
			cfg_q.env_fall_coef   <= 16'd65468;
			cfg_q.open_coef       <= 16'd64185;
			cfg_q.close_coef      <= 16'd65509;
			cfg_q.hold_length     <= 16'd480;
		end else if (cfg_we) begin
			// indexes past the last register are dropped
			case (cfg_addr)
				ngh_pkg::REG_THRESHOLD:  cfg_q.threshold_level <= cfg_wdata;
				ngh_pkg::REG_ENV_RISE:   cfg_q.env_rise_coef   <= cfg_wdata;
				ngh_pkg::REG_ENV_FALL:   cfg_q.env_fall_coef   <= cfg_wdata;
				ngh_pkg::REG_OPEN_COEF:  cfg_q.open_coef       <= cfg_wdata;
				ngh_pkg::REG_CLOSE_COEF: cfg_q.close_coef      <= cfg_wdata;
				ngh_pkg::REG_HOLD_LEN:   cfg_q.hold_length     <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

@@ src/ngh_datapath.sv @@
// Datapath: envelope, hold counter, gain state, one shared multiplier and
// the output register. Driven by commands from ngh_ctrl. Depends on ngh_pkg.
`default_nettype none
module ngh_datapath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire ngh_pkg::cfg_t                 cfg,
	input  wire ngh_pkg::cmd_t                 cmd,
	input  wire logic [ngh_pkg::TDATA_W-1:0]   in_data,
	output logic      [ngh_pkg::TDATA_W-1:0]   out_data,
	output logic                               out_gate
);

	localparam int SB = ngh_pkg::SAMPLE_BITS;

	logic [SB-1:0]                     raw;
	logic                              neg_in;
	logic [SB-1:0]                     mag_in;
	logic [SB-1:0]                     mag_q;
	logic                              neg_q;
	logic [ngh_pkg::ENV_W-1:0]         env_q;
	logic [ngh_pkg::GAIN_W-1:0]        gain_q;
	logic [ngh_pkg::HOLD_W-1:0]        hold_q;
	logic                              open_q;
	logic [ngh_pkg::ENV_W-1:0]         abs_q;
	logic signed [ngh_pkg::ENV_W:0]    env_diff;
	logic [ngh_pkg::GAIN_W-1:0]        gain_tgt;
	logic signed [ngh_pkg::GAIN_W:0]   gain_diff;
	logic [ngh_pkg::COEF_W-1:0]        env_coef;
	logic [ngh_pkg::COEF_W-1:0]        gain_coef;
	logic signed [ngh_pkg::A_W-1:0]    mul_a;
	logic signed [ngh_pkg::B_W-1:0]    mul_b;
	logic signed [ngh_pkg::P_W-1:0]    prod_q;
	logic signed [ngh_pkg::P_W-1:0]    prod_sh;
	logic signed [ngh_pkg::P_W-1:0]    env_sum;
	logic signed [ngh_pkg::P_W-1:0]    gain_sum;
	logic                              above;
	logic [SB-1:0]                     scaled;
	logic [SB-1:0]                     res;
	logic [SB-1:0]                     out_q;
	logic                              gate_q;

	always_comb begin
		raw    = in_data[SB-1:0];
		neg_in = raw[SB-1];
		// full-scale negative wraps to 2^(SB-1), which is the right magnitude
		mag_in = neg_in ? (~raw + SB'(1)) : raw;

		abs_q     = {mag_q, {ngh_pkg::FRAC_W{1'b0}}};
		env_coef  = (abs_q > env_q) ? cfg.env_rise_coef : cfg.env_fall_coef;
		env_diff  = $signed({1'b0, env_q}) - $signed({1'b0, abs_q});
		gain_tgt  = open_q ? ngh_pkg::GAIN_ONE : '0;
		gain_coef = (gain_tgt > gain_q) ? cfg.open_coef : cfg.close_coef;
		gain_diff = $signed({1'b0, gain_q}) - $signed({1'b0, gain_tgt});

		// one-pole: new = target + floor(c * (old - target) / 2^16)
		unique case (cmd.mul_sel)
			ngh_pkg::MUL_ENV: begin
				mul_a = $signed(ngh_pkg::A_W'(env_coef));
				mul_b = ngh_pkg::B_W'(env_diff);
			end
			ngh_pkg::MUL_GAIN: begin
				mul_a = $signed(ngh_pkg::A_W'(gain_coef));
				mul_b = ngh_pkg::B_W'(gain_diff);
			end
			ngh_pkg::MUL_OUT: begin
				mul_a = $signed(ngh_pkg::A_W'(mag_q));
				mul_b = $signed(ngh_pkg::B_W'(gain_q));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase

		prod_sh  = prod_q >>> ngh_pkg::FRAC_W;
		env_sum  = $signed(ngh_pkg::P_W'(abs_q)) + prod_sh;
		gain_sum = $signed(ngh_pkg::P_W'(gain_tgt)) + prod_sh;

		above = ngh_pkg::CMP_W'(env_q) >
			(ngh_pkg::CMP_W'(cfg.threshold_level) << ngh_pkg::FRAC_W);

		// gain <= 1.0, so the product shifted down fits the sample width
		scaled = prod_q[ngh_pkg::GAIN_FRAC +: SB];
		res    = neg_q ? (~scaled + SB'(1)) : scaled;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			env_q  <= '0;
			gain_q <= '0;
			hold_q <= '0;
			open_q <= 1'b0;
		end else begin
			if (cmd.env_upd)
				env_q <= env_sum[ngh_pkg::ENV_W-1:0];
			if (cmd.gate_upd) begin
				priority if (above) begin
					open_q <= 1'b1;
					hold_q <= cfg.hold_length;
				end else if (hold_q != '0) begin
					open_q <= 1'b1;
					hold_q <= hold_q - ngh_pkg::HOLD_W'(1);
				end else begin
					open_q <= 1'b0;
				end
			end
			if (cmd.gain_upd)
				gain_q <= gain_sum[ngh_pkg::GAIN_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			mag_q <= mag_in;
			neg_q <= neg_in;
		end
		if (cmd.mul_en)
			prod_q <= mul_a * mul_b;
		if (cmd.out_load) begin
			out_q  <= res;
			gate_q <= open_q;
		end
	end

	assign out_data = ngh_pkg::TDATA_W'(out_q);
	assign out_gate = gate_q;

endmodule
`default_nettype wire

@@ src/ngh_ctrl.sv @@
// Controller: sequences one sample through the shared multiplier and owns
// both handshakes. Depends on ngh_pkg.
`default_nettype none
module ngh_ctrl (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  wire logic     out_ready,
	output ngh_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ENV_MUL,
		ST_ENV_UPD,
		ST_GATE,
		ST_GAIN_MUL,
		ST_GAIN_UPD,
		ST_OUT_MUL,
		ST_OUT_WR
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		cmd          = '0;
		cmd.mul_sel  = ngh_pkg::MUL_ENV;
		unique case (state_q)
			ST_IDLE:     cmd.load_in = in_valid;
			ST_ENV_MUL:  cmd.mul_en  = 1'b1;
			ST_ENV_UPD:  cmd.env_upd = 1'b1;
			ST_GATE:     cmd.gate_upd = 1'b1;
			ST_GAIN_MUL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = ngh_pkg::MUL_GAIN;
			end
			ST_GAIN_UPD: cmd.gain_upd = 1'b1;
			ST_OUT_MUL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = ngh_pkg::MUL_OUT;
			end
			ST_OUT_WR:   cmd.out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// a new result may take the register in the cycle the old one transfers
			priority if (state_q == ST_OUT_WR && out_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE:     if (in_valid) state_q <= ST_ENV_MUL;
				ST_ENV_MUL:  state_q <= ST_ENV_UPD;
				ST_ENV_UPD:  state_q <= ST_GATE;
				ST_GATE:     state_q <= ST_GAIN_MUL;
				ST_GAIN_MUL: state_q <= ST_GAIN_UPD;
				ST_GAIN_UPD: state_q <= ST_OUT_MUL;
				ST_OUT_MUL:  state_q <= ST_OUT_WR;
				ST_OUT_WR: begin
					// wait here while the previous result is still unclaimed
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

@@ src/noise_gate_with_hold.sv @@
// Noise gate with hold: top level joining config registers, controller and datapath.
// Depends on ngh_pkg, ngh_cfg_regs, ngh_ctrl, ngh_datapath.
//
// Usage:
//   s_axis carries one signed sample per transfer in tdata; m_axis returns the
//   gated sample in tdata and the gate state in tuser, one result per sample,
//   in order. Registers are to be written through cfg_we/cfg_addr/cfg_wdata
//   while the block is idle, which the block itself does not enforce; writes
//   to unused indexes are dropped. Per sample the controller walks eight
//   states: accept, envelope multiply, envelope update, gate/hold decision,
//   gain multiply, gain update, output multiply, output write. All three
//   products go through one shared multiplier; m_axis_tvalid rises once the
//   output-write state has loaded the result, and the block takes no new
//   sample until the current one has left the output-write state.
//   The output register decouples the sides: the next sample is accepted while
//   a result waits. If the receiver stalls, the following sample finishes its
//   work and then waits in the output-write state until the register frees up;
//   s_axis_tready stays low meanwhile.
//   Reset clears the envelope, gain (gate closed) and hold counter, loads the
//   default register values and leaves m_axis_tvalid low.
`default_nettype none
module noise_gate_with_hold (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	input  wire logic [ngh_pkg::TDATA_W-1:0]   s_axis_tdata,   // [15:0] sample_in
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	output logic      [ngh_pkg::TDATA_W-1:0]   m_axis_tdata,   // [15:0] sample_out
	output logic      [0:0]                    m_axis_tuser,   // [0] gate_open
	input  wire logic                          cfg_we,
	input  wire logic [ngh_pkg::CFG_AW-1:0]    cfg_addr,
	input  wire logic [ngh_pkg::CFG_DW-1:0]    cfg_wdata
);

	ngh_pkg::cfg_t cfg;
	ngh_pkg::cmd_t cmd;
	logic          gate;

	ngh_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	ngh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd)
	);

	ngh_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cmd      (cmd),
		.in_data  (s_axis_tdata),
		.out_data (m_axis_tdata),
		.out_gate (gate)
	);

	assign m_axis_tuser = gate;

endmodule
`default_nettype wire
